### src/lof_pkg.sv
// Shared types and constants for the longest-ones-with-k-flips block.
// Beat payloads and configuration register map; no dependencies.
package lof_pkg;

	localparam int OUT_W = 16;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [0:0] {
		REG_MAX_FLIPS = 1'b0,
		REG_NONE      = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic bit_value;
		logic last_bit;
	} in_t;

	typedef struct packed {
		logic [OUT_W-1:0] window_len;
		logic [OUT_W-1:0] best_len;
		logic             done_res;
	} out_t;

endpackage

### src/lof_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lof_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/lof_ring.sv
// Zero-position ring control: head, tail, zero count and element index.
// Drives the ring memory ports; used by longest_ones_with_k_flips.
module lof_ring #(
	parameter int MAX_FLIPS_LIMIT = 255,
	parameter int COUNT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             take,
	input  logic                             bit_value,
	input  logic                             last_bit,
	input  logic [7:0]                       max_flips,
	output logic                             we,
	output logic [$clog2(MAX_FLIPS_LIMIT+1)-1:0] waddr,
	output logic [COUNT_BITS-1:0]            wdata,
	output logic                             re,
	output logic [$clog2(MAX_FLIPS_LIMIT+1)-1:0] raddr,
	output logic                             pop,
	output logic                             pop_cur,
	output logic [COUNT_BITS-1:0]            cur
);

	localparam int DEPTH = MAX_FLIPS_LIMIT + 1;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(MAX_FLIPS_LIMIT + 2);
	localparam int SW = CW + 2;
	localparam logic [16:0] LIM17 = 17'(MAX_FLIPS_LIMIT);
	localparam logic [COUNT_BITS-1:0] POS_MAX = {COUNT_BITS{1'b1}};

	logic [AW-1:0]         head_q, tail_q, tail_nx, head_nx;
	logic [CW-1:0]         count_q, count_new, limit, drop;
	logic [COUNT_BITS-1:0] pos_q;
	logic [16:0]           flips17, lim17;
	logic [SW-1:0]         rsum, rwrap, hsum, hwrap;
	logic                  zero, over;

	always_comb begin
		flips17 = {9'd0, max_flips};
		lim17 = (flips17 > LIM17) ? LIM17 : flips17;
		limit = lim17[CW-1:0];
		zero = !bit_value;
		count_new = count_q + CW'(zero);
		over = count_new > limit;
		drop = over ? count_new - limit : '0;
		rsum = SW'(head_q) + SW'(drop) - SW'(1);
		rwrap = (rsum >= SW'(DEPTH)) ? rsum - SW'(DEPTH) : rsum;
		hsum = SW'(head_q) + SW'(drop);
		hwrap = (hsum >= SW'(DEPTH)) ? hsum - SW'(DEPTH) : hsum;
		head_nx = hwrap[AW-1:0];
		tail_nx = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
	end

	assign we = take && zero;
	assign waddr = tail_q;
	assign wdata = pos_q;
	assign re = take && over;
	assign raddr = rwrap[AW-1:0];
	assign pop = over;
	assign pop_cur = zero && (drop == count_new);
	assign cur = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			pos_q <= '0;
		end else if (take) begin
			if (last_bit) begin
				head_q <= '0;
				tail_q <= '0;
				count_q <= '0;
				pos_q <= '0;
			end else begin
				head_q <= head_nx;
				tail_q <= zero ? tail_nx : tail_q;
				count_q <= over ? limit : count_new;
				pos_q <= (pos_q == POS_MAX) ? pos_q : pos_q + COUNT_BITS'(1);
			end
		end
	end

endmodule

### src/longest_ones_with_k_flips.sv
// Longest window of ones with at most max_flips zeros, one bit per input beat.
// Beat registered in stage 1, result in stage 2; out_stall holds both stages.
// Throughput: one beat per cycle while out_stall is low, set by one ring-memory
// read per beat for the oldest dropped zero.
// Reset clears all control state and max_flips; the ring needs no clearing pass.
// Depends on lof_pkg, lof_ring, lof_ram.
module longest_ones_with_k_flips
	import lof_pkg::*;
#(
	parameter int MAX_FLIPS_LIMIT = 255,
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data
);

	localparam int DEPTH = MAX_FLIPS_LIMIT + 1;
	localparam int AW = $clog2(DEPTH);
	localparam int LW = COUNT_BITS + 1;
	localparam logic [LW-1:0] COUNT_MAX = {1'b0, {COUNT_BITS{1'b1}}};

	logic [7:0]            max_flips_q;
	logic                  take, move, out_valid_q;
	logic                  we, re, pop, pop_cur;
	logic [AW-1:0]         waddr, raddr;
	logic [COUNT_BITS-1:0] wdata, rdata, cur;
	logic                  valid_s1, pop_s1, pop_cur_s1, last_s1;
	logic [COUNT_BITS-1:0] cur_s1;
	logic [LW-1:0]         ws_q, ws_new, cur_ext, len;
	logic [COUNT_BITS-1:0] best_q, len_sat, best_new, zpos;
	logic [32:0]           len_ext, best_ext;
	reg_idx_t              reg_idx;

	assign reg_idx = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign prdata = (reg_idx == REG_MAX_FLIPS) ? {24'd0, max_flips_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_flips_q <= '0;
		end else if (psel && penable && pwrite && reg_idx == REG_MAX_FLIPS) begin
			max_flips_q <= pwdata[7:0];
		end
	end

	assign move = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !move;
	assign take = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	lof_ring #(
		.MAX_FLIPS_LIMIT(MAX_FLIPS_LIMIT),
		.COUNT_BITS(COUNT_BITS)
	) u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.bit_value(in_data.bit_value),
		.last_bit(in_data.last_bit),
		.max_flips(max_flips_q),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr(raddr),
		.pop(pop),
		.pop_cur(pop_cur),
		.cur(cur)
	);

	lof_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(DEPTH)
	) u_zero_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Stage 1: hold beat while the ring read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pop_s1 <= pop;
			pop_cur_s1 <= pop_cur;
			last_s1 <= in_data.last_bit;
			cur_s1 <= cur;
		end
	end

	// Stage 2: window start, length, best
	always_comb begin
		zpos = pop_cur_s1 ? cur_s1 : rdata;
		ws_new = pop_s1 ? {1'b0, zpos} + LW'(1) : ws_q;
		cur_ext = {1'b0, cur_s1};
		len = (ws_new > cur_ext) ? '0 : cur_ext - ws_new + LW'(1);
		len_sat = (len > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0] : len[COUNT_BITS-1:0];
		best_new = (len_sat > best_q) ? len_sat : best_q;
		len_ext = 33'(len_sat);
		best_ext = 33'(best_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ws_q <= '0;
			best_q <= '0;
		end else if (move) begin
			out_valid_q <= 1'b1;
			ws_q <= last_s1 ? '0 : ws_new;
			best_q <= last_s1 ? '0 : best_new;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_data.window_len <= (len_ext > 33'd65535) ? 16'hFFFF : len_ext[OUT_W-1:0];
			out_data.best_len <= (best_ext > 33'd65535) ? 16'hFFFF : best_ext[OUT_W-1:0];
			out_data.done_res <= last_s1;
		end
	end

endmodule

### tb/tb_longest_ones_with_k_flips.sv
// Testbench for longest_ones_with_k_flips: streams binary arrays under several
// max_flips settings and checks every result beat against a sliding-window predictor.
// Depends on lof_pkg and the longest_ones_with_k_flips RTL.
`timescale 1ns / 1ps

module tb_longest_ones_with_k_flips;
	import lof_pkg::*;

	localparam int MAX_FLIPS_LIMIT = 255;
	localparam int COUNT_BITS = 16;
	localparam int RING_DEPTH = MAX_FLIPS_LIMIT + 1;
	localparam longint COUNT_MAX = (longint'(1) << COUNT_BITS) - 1;
	localparam longint OUT_MAX = 65535;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_BITS = 1300;

	class flip_window_model;
		logic [7:0] max_flips;
		longint position;
		longint window_start;
		int zero_count;
		longint best_so_far;
		longint zero_at [RING_DEPTH];
		int head;
		int tail;
		out_t expected_lengths [$];
		int mismatches;

		function new();
			max_flips = '0;
			mismatches = 0;
			clear_array();
		endfunction

		function void clear_array();
			position = 0;
			window_start = 0;
			zero_count = 0;
			best_so_far = 0;
			head = 0;
			tail = 0;
			foreach (zero_at[i]) zero_at[i] = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_MAX_FLIPS) max_flips = value[7:0];
		endfunction

		function void take_bit(in_t beat);
			int lim;
			longint cur;
			longint len;
			out_t want;
			lim = (int'(max_flips) > MAX_FLIPS_LIMIT) ? MAX_FLIPS_LIMIT : int'(max_flips);
			cur = position;
			if (beat.bit_value == 1'b0) begin
				if (zero_count >= RING_DEPTH) begin
					window_start = zero_at[head] + 1;
					head = (head + 1) % RING_DEPTH;
					zero_count--;
				end
				zero_at[tail] = cur;
				tail = (tail + 1) % RING_DEPTH;
				zero_count++;
			end
			while (zero_count > lim) begin
				window_start = zero_at[head] + 1;
				head = (head + 1) % RING_DEPTH;
				zero_count--;
			end
			len = (window_start > cur) ? 0 : cur - window_start + 1;
			if (len > COUNT_MAX) len = COUNT_MAX;
			if (len > best_so_far) best_so_far = len;
			want.window_len = OUT_W'((len > OUT_MAX) ? OUT_MAX : len);
			want.best_len = OUT_W'((best_so_far > OUT_MAX) ? OUT_MAX : best_so_far);
			want.done_res = beat.last_bit;
			expected_lengths.push_back(want);
			if (position < COUNT_MAX) position++;
			if (beat.last_bit) clear_array();
		endfunction

		function void check_lengths(out_t got);
			out_t want;
			if (expected_lengths.size() == 0) begin
				$error("unexpected result beat: window_len %0d best_len %0d done_res %0d",
					got.window_len, got.best_len, got.done_res);
				mismatches++;
				return;
			end
			want = expected_lengths.pop_front();
			if (got.window_len !== want.window_len) begin
				$error("window_len: expected %0d, actual %0d", want.window_len, got.window_len);
				mismatches++;
			end
			if (got.best_len !== want.best_len) begin
				$error("best_len: expected %0d, actual %0d", want.best_len, got.best_len);
				mismatches++;
			end
			if (got.done_res !== want.done_res) begin
				$error("done_res: expected %0d, actual %0d", want.done_res, got.done_res);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;

	flip_window_model model = new();
	int cycles = 0;
	int burst_left = 1;
	bit gaps_on = 1'b1;

	longest_ones_with_k_flips uut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** longest_ones_with_k_flips: FAILED **");
			$finish;
		end
	end

	// check each result beat before the edge that accepts it
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) model.check_lengths(out_data);
	end

	initial begin
		int mode;
		int phase;
		out_stall <= 1'b0;
		phase = 0;
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(20, 200)) begin
				@(posedge clk);
				phase++;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= (phase % 3 == 0);
				endcase
			end
		end
	end

	task automatic cfg_access(input bit wr, input reg_idx_t idx,
		input logic [CFG_DATA_W-1:0] data, output logic [CFG_DATA_W-1:0] rd);
		logic rdy;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= CFG_ADDR_W'(4 * int'(idx));
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		forever begin
			@(negedge clk);
			rdy = pready;
			rd = prdata;
			@(posedge clk);
			if (rdy) break;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		logic [CFG_DATA_W-1:0] rd;
		cfg_access(1'b1, idx, value, rd);
		model.set_reg(idx, value);
		cfg_access(1'b0, REG_MAX_FLIPS, '0, rd);
		if (rd !== CFG_DATA_W'(model.max_flips)) begin
			$error("max_flips readback: expected %0d, actual %0d", model.max_flips, rd);
			model.mismatches++;
		end
	endtask

	task automatic send_bit(input logic bv, input logic lb);
		in_t beat;
		logic took;
		beat.bit_value = bv;
		beat.last_bit = lb;
		in_valid <= 1'b1;
		in_data <= beat;
		forever begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
			if (took) break;
		end
		model.take_bit(beat);
		if (gaps_on) begin
			if (burst_left <= 1) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
					: $urandom_range(1, 12);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_pattern(input string bits, input bit close);
		for (int i = 0; i < bits.len(); i++)
			send_bit(bits[i] == "1", close && i == bits.len() - 1);
	endtask

	task automatic send_array(input int len, input int zero_pct, input bit close);
		for (int i = 0; i < len; i++)
			send_bit($urandom_range(0, 99) >= zero_pct, close && i == len - 1);
	endtask

	// hold off until every result beat is back
	task automatic drain();
		in_valid <= 1'b0;
		while (model.expected_lengths.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int total;
		int narr;
		int len;
		int pct;
		logic [CFG_DATA_W-1:0] word;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pattern("1101001", 1'b1);
		drain();
		set_reg(REG_NONE, 32'hFFFF_FFFF);
		send_pattern("0", 1'b1);
		send_pattern("1", 1'b1);
		drain();
		set_reg(REG_MAX_FLIPS, 32'h0000_00FF);
		send_pattern("000101", 1'b1);
		drain();
		set_reg(REG_MAX_FLIPS, 32'hABCD_EF02);
		send_pattern("01010", 1'b0);
		drain();
		set_reg(REG_MAX_FLIPS, 32'h0000_0000);
		send_pattern("101", 1'b1);
		drain();

		total = 0;
		while (total < RANDOM_BITS) begin
			word = $urandom();
			case ($urandom_range(0, 5))
				0: word[7:0] = 8'd0;
				1: word[7:0] = 8'd1;
				2: word[7:0] = 8'd255;
				3: word[7:0] = 8'($urandom_range(2, 8));
				default: word[7:0] = 8'($urandom_range(0, 255));
			endcase
			if ($urandom_range(0, 7) == 0) set_reg(REG_NONE, $urandom());
			set_reg(REG_MAX_FLIPS, word);
			narr = $urandom_range(1, 4);
			for (int a = 0; a < narr; a++) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 300)
					: $urandom_range(1, 40);
				case ($urandom_range(0, 4))
					0: pct = 0;
					1: pct = 100;
					2: pct = $urandom_range(1, 20);
					3: pct = $urandom_range(20, 80);
					default: pct = $urandom_range(0, 100);
				endcase
				send_array(len, pct, !(a == narr - 1 && $urandom_range(0, 2) == 0));
				total += len;
			end
			drain();
		end

		drain();
		repeat (6) @(posedge clk);
		if (model.mismatches == 0) begin
			$display("** longest_ones_with_k_flips: PASSED **");
		end else begin
			$display("** longest_ones_with_k_flips: FAILED **");
		end
		$finish;
	end

endmodule
